// ----- sv/crpg_pkg.sv -----
// Package for the charger power ramp governor.
// Holds the shared constants, register indexes, fault codes and the flag struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crpg_pkg;

    // Default configuration of the top-level parameters.
    localparam int PWM_PERIOD_DEF  = 512;
    localparam int START_STEPS_DEF = 255;

    // Field widths.
    localparam int ADC_W   = 12;
    localparam int CFG_W   = 15;
    localparam int POWER_W = 10;
    localparam int STEP_W  = 8;
    localparam int FAULT_W = 3;
    localparam int TICK_W  = 2;

    // Width of a voltage sample times its millivolt scale (4095 * 6683 < 2**25).
    localparam int PROD_W = 25;
    // Width of the near-target comparison (20 * 32767 + 20 < 2**20).
    localparam int NEAR_W = 20;

    // Scale factors.
    localparam logic [PROD_W-1:0] MV_NUM   = 25'd6683;
    localparam logic [PROD_W-1:0] MV_DEN   = 25'd1000;
    localparam logic [CFG_W-1:0]  I_SCALE  = 15'd7;
    localparam logic [NEAR_W-1:0] NEAR_DIV = 20'd20;

    // Voltage limits expressed on the unscaled product, so that no divider is needed:
    // floor(p / 1000) < 8000 when p < 8000000, and > 20000 when p >= 20001000.
    localparam logic [PROD_W-1:0] UIN_LOW_PROD   = 25'd8000000;
    localparam logic [PROD_W-1:0] UIN_HIGH_PROD  = 25'd20001000;
    localparam logic [PROD_W-1:0] UOUT_HIGH_PROD = 25'd30001000;

    // Current limits in tenths of milliamps.
    localparam logic [CFG_W-1:0] IOUT_HIGH         = 15'd26000;
    localparam logic [CFG_W-1:0] NEAR_MIN_SETPOINT = 15'd3000;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] VOLTAGE_LIMIT_RESET    = 15'd24900;
    localparam logic [CFG_W-1:0] CURRENT_SETPOINT_RESET = 15'd0;

    // Configuration register indexes.
    localparam logic REG_VOLTAGE_LIMIT    = 1'b0;
    localparam logic REG_CURRENT_SETPOINT = 1'b1;

    // Fault codes; the lowest applicable one is reported.
    localparam logic [FAULT_W-1:0] FAULT_NONE      = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_UIN_LOW   = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_UIN_HIGH  = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_IOUT_HIGH = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_UOUT_HIGH = 3'd4;

    // Measurement flags handed from the measurement stage to the regulator.
    typedef struct packed {
        logic [FAULT_W-1:0] fault_code;
        logic               ramp_up;      // output voltage and current both under limit
        logic               near_target;  // current close to a large enough setpoint
    } meas_flags_t;

endpackage

`default_nettype wire

// ----- sv/crpg_measure.sv -----
// Measurement logic of the charger power ramp governor: scaling, fault code
// and the limit and near-target comparisons. Depends on crpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crpg_measure
(
    input  wire logic [crpg_pkg::ADC_W-1:0] adc_input_voltage,
    input  wire logic [crpg_pkg::ADC_W-1:0] adc_output_voltage,
    input  wire logic [crpg_pkg::ADC_W-1:0] adc_output_current,
    input  wire logic [crpg_pkg::CFG_W-1:0] voltage_limit,
    input  wire logic [crpg_pkg::CFG_W-1:0] current_setpoint,
    output crpg_pkg::meas_flags_t           flags
);

    logic [crpg_pkg::PROD_W-1:0]  uin_prod;
    logic [crpg_pkg::PROD_W-1:0]  uout_prod;
    logic [crpg_pkg::PROD_W-1:0]  vlimit_prod;
    logic [crpg_pkg::CFG_W-1:0]   i_out;
    logic [crpg_pkg::CFG_W-1:0]   cur_diff;
    logic [crpg_pkg::NEAR_W-1:0]  diff_scaled;
    logic [crpg_pkg::FAULT_W-1:0] fault_code;
    logic                         ramp_up;
    logic                         near_target;

    // Voltages stay in the unscaled product domain; the limit is scaled up instead.
    assign uin_prod    = crpg_pkg::PROD_W'(adc_input_voltage) * crpg_pkg::MV_NUM;
    assign uout_prod   = crpg_pkg::PROD_W'(adc_output_voltage) * crpg_pkg::MV_NUM;
    assign vlimit_prod = crpg_pkg::PROD_W'(voltage_limit) * crpg_pkg::MV_DEN;

    // Current in tenths of milliamps; 4095 * 7 fits in 15 bits.
    assign i_out = crpg_pkg::CFG_W'(adc_output_current) * crpg_pkg::I_SCALE;

    // Distance between measured current and setpoint.
    assign cur_diff = (i_out > current_setpoint) ? (i_out - current_setpoint)
                                                 : (current_setpoint - i_out);

    // cur_diff < floor(sp / 20) holds exactly when 20 * cur_diff + 20 <= sp.
    assign diff_scaled = crpg_pkg::NEAR_W'(cur_diff) * crpg_pkg::NEAR_DIV + crpg_pkg::NEAR_DIV;

    // Fault code, the lowest applicable code taking priority.
    always_comb
    begin
        priority if (uin_prod < crpg_pkg::UIN_LOW_PROD)
        begin
            fault_code = crpg_pkg::FAULT_UIN_LOW;
        end
        else if (uin_prod >= crpg_pkg::UIN_HIGH_PROD)
        begin
            fault_code = crpg_pkg::FAULT_UIN_HIGH;
        end
        else if (i_out > crpg_pkg::IOUT_HIGH)
        begin
            fault_code = crpg_pkg::FAULT_IOUT_HIGH;
        end
        else if (uout_prod >= crpg_pkg::UOUT_HIGH_PROD)
        begin
            fault_code = crpg_pkg::FAULT_UOUT_HIGH;
        end
        else
        begin
            fault_code = crpg_pkg::FAULT_NONE;
        end
    end

    // Ramp direction and near-target detection.
    assign ramp_up     = (uout_prod < vlimit_prod) && (i_out < current_setpoint);
    assign near_target = (diff_scaled <= crpg_pkg::NEAR_W'(current_setpoint))
                         && (current_setpoint > crpg_pkg::NEAR_MIN_SETPOINT);

    assign flags = {fault_code, ramp_up, near_target};

endmodule

`default_nettype wire

// ----- sv/charger_power_ramp_governor_unit.sv -----
// Top level of the charger power ramp governor: stream handshake, configuration
// registers, regulator state and the result register. Depends on crpg_pkg and crpg_measure.
//
// Channel   Direction  Content
// s_*       in         ADC sample set: input voltage, output voltage, output current
// m_*       out        power level, start step, drive enable, fault code
// cfg_*     in         register write: 0 voltage limit, 1 current setpoint
//
// Each transaction passes an input register, then the measurement and regulator logic into
// the result register. One transaction is accepted every cycle while the result side takes
// results.
// While a finished result waits in the result register, the input register takes one more
// transaction and then holds s_tready low until the result is taken.
// Reset clears the regulator state, loads the start step count and the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module charger_power_ramp_governor_unit
#(
    parameter int PWM_PERIOD  = crpg_pkg::PWM_PERIOD_DEF,
    parameter int START_STEPS = crpg_pkg::START_STEPS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [11:0] adc_input_voltage, [23:12] adc_output_voltage, [35:24] adc_output_current
    input  wire logic [39:0] s_tdata,
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [9:0] power_level, [17:10] start_step, [18] drive_enable, [21:19] fault_code
    output logic [23:0]      m_tdata,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_data
);

    localparam int CAP_RAW = (PWM_PERIOD * 17) / 10;
    localparam logic [crpg_pkg::POWER_W-1:0] POWER_CAP =
        (CAP_RAW > 1023) ? 10'd1023 : crpg_pkg::POWER_W'(CAP_RAW);
    localparam logic [crpg_pkg::STEP_W-1:0] START_LOAD = crpg_pkg::STEP_W'(START_STEPS);
    localparam logic [crpg_pkg::TICK_W-1:0] TICK_WRAP  = 2'd3;

    logic [crpg_pkg::CFG_W-1:0]   vlimit_reg;
    logic [crpg_pkg::CFG_W-1:0]   setpoint_reg;
    logic                         in_valid_reg;
    logic [3*crpg_pkg::ADC_W-1:0] in_data_reg;
    logic                         out_valid_reg;
    logic [23:0]                  out_data_reg;
    logic [crpg_pkg::POWER_W-1:0] power_reg;
    logic [crpg_pkg::POWER_W-1:0] power_next;
    logic [crpg_pkg::STEP_W-1:0]  steps_reg;
    logic [crpg_pkg::STEP_W-1:0]  steps_next;
    logic [crpg_pkg::TICK_W-1:0]  ticks_reg;
    logic [crpg_pkg::TICK_W-1:0]  ticks_next;
    logic [crpg_pkg::TICK_W-1:0]  ticks_inc;
    logic                         advance;
    logic                         enable;
    crpg_pkg::meas_flags_t        flags;

    // The item in the input register moves on whenever the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlimit_reg   <= crpg_pkg::VOLTAGE_LIMIT_RESET;
            setpoint_reg <= crpg_pkg::CURRENT_SETPOINT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crpg_pkg::REG_VOLTAGE_LIMIT:    vlimit_reg   <= cfg_data;
                crpg_pkg::REG_CURRENT_SETPOINT: setpoint_reg <= cfg_data;
                default:                        vlimit_reg   <= vlimit_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[3*crpg_pkg::ADC_W-1:0];
        end
    end

    // Scaling, fault code and comparisons.
    crpg_measure u_measure
    (
        .adc_input_voltage  (in_data_reg[crpg_pkg::ADC_W-1:0]),
        .adc_output_voltage (in_data_reg[2*crpg_pkg::ADC_W-1:crpg_pkg::ADC_W]),
        .adc_output_current (in_data_reg[3*crpg_pkg::ADC_W-1:2*crpg_pkg::ADC_W]),
        .voltage_limit      (vlimit_reg),
        .current_setpoint   (setpoint_reg),
        .flags              (flags)
    );

    // Regulator: power ramp and soft-start step count.
    assign ticks_inc = ticks_reg + 2'd1;

    always_comb
    begin
        power_next = power_reg;
        steps_next = steps_reg;
        ticks_next = ticks_reg;
        enable     = 1'b0;
        if (setpoint_reg == '0)
        begin
            // Drive off: clear power and reload the start steps.
            power_next = '0;
            steps_next = START_LOAD;
        end
        else
        begin
            enable = 1'b1;
            if (flags.ramp_up)
            begin
                if (power_reg < POWER_CAP)
                begin
                    power_next = power_reg + 10'd1;
                end
            end
            else if (power_reg != '0)
            begin
                power_next = power_reg - 10'd1;
            end
            // Every third near-target transaction lowers the start step count.
            if (flags.near_target)
            begin
                if (ticks_inc == TICK_WRAP)
                begin
                    ticks_next = '0;
                    if (steps_reg != '0)
                    begin
                        steps_next = steps_reg - 8'd1;
                    end
                end
                else
                begin
                    ticks_next = ticks_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= '0;
            steps_reg <= START_LOAD;
            ticks_reg <= '0;
        end
        else if (advance)
        begin
            power_reg <= power_next;
            steps_reg <= steps_next;
            ticks_reg <= ticks_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {2'b00, flags.fault_code, enable, steps_next, power_next};
        end
    end

endmodule

`default_nettype wire

// ----- tb/charger_power_ramp_governor_unit_tb.sv -----
// Self-checking testbench for charger_power_ramp_governor_unit.
// Drives ADC sample sets through the stream ports and checks every result against a
// predictor of its own. Depends on crpg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module charger_power_ramp_governor_unit_tb;

    // Ramp ceiling and reload value for the default parameters of the block.
    localparam int POWER_CAP_RAW = crpg_pkg::PWM_PERIOD_DEF * 17 / 10;
    localparam int POWER_CAP     = (POWER_CAP_RAW > 1023) ? 1023 : POWER_CAP_RAW;
    localparam logic [crpg_pkg::STEP_W-1:0] STEP_RELOAD =
        crpg_pkg::STEP_W'(crpg_pkg::START_STEPS_DEF);

    // Millivolt scaling and fixed fault thresholds.
    localparam int unsigned MV_MUL      = 6683;
    localparam int unsigned MV_DIV      = 1000;
    localparam int unsigned CUR_MUL     = 7;
    localparam int unsigned UIN_LOW_MV  = 8000;
    localparam int unsigned UIN_HIGH_MV = 20000;
    localparam int unsigned UOUT_MAX_MV = 30000;

    // Raw input voltage samples that convert into the healthy supply window.
    localparam int ADC_IN_OK_MIN = 1198;
    localparam int ADC_IN_OK_MAX = 2992;
    localparam int ADC_MAX       = 4095;

    // One ADC sample set; the packed order matches s_tdata[35:0], first member in the highest bits.
    typedef struct packed {
        logic [crpg_pkg::ADC_W-1:0] adc_cur;
        logic [crpg_pkg::ADC_W-1:0] adc_out;
        logic [crpg_pkg::ADC_W-1:0] adc_in;
    } sample_t;

    // One result; the packed order matches m_tdata[21:0].
    typedef struct packed {
        logic [crpg_pkg::FAULT_W-1:0] fault;
        logic                         enable;
        logic [crpg_pkg::STEP_W-1:0]  step;
        logic [crpg_pkg::POWER_W-1:0] power;
    } ramp_result_t;

    typedef enum {SAMPLE_NOISE, SAMPLE_RAMP_NEAR, SAMPLE_AROUND} sample_kind_t;
    typedef enum {RX_ALWAYS, RX_COIN, RX_THIRD, RX_MOSTLY, RX_HOLD} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [14:0] cfg_data = '0;

    // Predictor copy of the configuration and the regulator state.
    logic [crpg_pkg::CFG_W-1:0]   volt_limit_cfg = crpg_pkg::VOLTAGE_LIMIT_RESET;
    logic [crpg_pkg::CFG_W-1:0]   setpoint_cfg = crpg_pkg::CURRENT_SETPOINT_RESET;
    logic [crpg_pkg::POWER_W-1:0] power_st = '0;
    logic [crpg_pkg::STEP_W-1:0]  step_st = STEP_RELOAD;
    logic [crpg_pkg::TICK_W-1:0]  near_ticks_st = '0;

    sample_t      samples_pending[$];
    ramp_result_t ramp_expected[$];
    int           samples_queued = 0;
    int           samples_accepted = 0;
    int           mismatch_count = 0;
    bit           in_taken = 1'b0;

    // Sender burst state and receiver stall state.
    int       burst_left = 0;
    int       gap_left = 0;
    int       rx_cycle = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    charger_power_ramp_governor_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Works out the result of one sample set and advances the regulator state.
    function automatic ramp_result_t governor_predict(input sample_t smp);
        int unsigned  u_in;
        int unsigned  u_out;
        int unsigned  i_out;
        int unsigned  cur_diff;
        ramp_result_t res;
        u_in  = int'(smp.adc_in) * MV_MUL / MV_DIV;
        u_out = int'(smp.adc_out) * MV_MUL / MV_DIV;
        i_out = int'(smp.adc_cur) * CUR_MUL;
        res.enable = 1'b0;

        // Lowest applicable fault code wins.
        if (u_in < UIN_LOW_MV)
            res.fault = crpg_pkg::FAULT_UIN_LOW;
        else if (u_in > UIN_HIGH_MV)
            res.fault = crpg_pkg::FAULT_UIN_HIGH;
        else if (i_out > crpg_pkg::IOUT_HIGH)
            res.fault = crpg_pkg::FAULT_IOUT_HIGH;
        else if (u_out > UOUT_MAX_MV)
            res.fault = crpg_pkg::FAULT_UOUT_HIGH;
        else
            res.fault = crpg_pkg::FAULT_NONE;

        if (setpoint_cfg == '0)
        begin
            // Drive off: power cleared, soft start reloaded, tick count kept.
            power_st = '0;
            step_st  = STEP_RELOAD;
        end
        else
        begin
            res.enable = 1'b1;
            if (u_out < volt_limit_cfg && i_out < setpoint_cfg)
            begin
                if (power_st < POWER_CAP)
                    power_st = power_st + 1'b1;
            end
            else if (power_st > 0)
            begin
                power_st = power_st - 1'b1;
            end

            // Every third tick close to a large enough setpoint lowers the soft start.
            cur_diff = (i_out > setpoint_cfg) ? i_out - setpoint_cfg : setpoint_cfg - i_out;
            if (cur_diff < setpoint_cfg / 20 && setpoint_cfg > crpg_pkg::NEAR_MIN_SETPOINT)
            begin
                near_ticks_st = near_ticks_st + 1'b1;
                if (near_ticks_st == 2'd3)
                begin
                    near_ticks_st = '0;
                    if (step_st > 0)
                        step_st = step_st - 1'b1;
                end
            end
        end
        res.power = power_st;
        res.step  = step_st;
        return res;
    endfunction

    // Draws a random sample set shaped for the current setpoint and voltage limit.
    function automatic sample_t draw_sample(input sample_kind_t kind);
        sample_t smp;
        int      sp;
        int      lo;
        int      hi;
        int      span;
        int      cur;
        sp = int'(setpoint_cfg);
        smp.adc_in  = crpg_pkg::ADC_W'($urandom_range(ADC_IN_OK_MIN, ADC_IN_OK_MAX));
        smp.adc_out = crpg_pkg::ADC_W'($urandom_range(0, ADC_MAX));
        case (kind)
            SAMPLE_RAMP_NEAR:
            begin
                // Output below its limit and current just under the setpoint.
                if (int'(smp.adc_out) * MV_MUL / MV_DIV >= volt_limit_cfg)
                    smp.adc_out = '0;
                lo = (sp - sp / 20) / 7 + 1;
                hi = (sp - 1) / 7;
                if (hi > ADC_MAX)
                    hi = ADC_MAX;
                if (hi < 0)
                    hi = 0;
                if (lo > hi)
                    lo = hi;
                if (lo < 0)
                    lo = 0;
                smp.adc_cur = crpg_pkg::ADC_W'($urandom_range(lo, hi));
            end
            SAMPLE_AROUND:
            begin
                // Current spread around the setpoint; the supply is sometimes off.
                if ($urandom_range(0, 9) == 0)
                    smp.adc_in = crpg_pkg::ADC_W'($urandom_range(0, ADC_MAX));
                span = sp / 70 + 8;
                cur  = sp / 7 + int'($urandom_range(0, 2 * span)) - span;
                if (cur < 0)
                    cur = 0;
                if (cur > ADC_MAX)
                    cur = ADC_MAX;
                smp.adc_cur = crpg_pkg::ADC_W'(cur);
            end
            default:
            begin
                smp.adc_in  = crpg_pkg::ADC_W'($urandom_range(0, ADC_MAX));
                smp.adc_cur = crpg_pkg::ADC_W'($urandom_range(0, ADC_MAX));
            end
        endcase
        return smp;
    endfunction

    task automatic push_sample(input sample_t smp);
        samples_pending.push_back(smp);
        samples_queued++;
    endtask

    // Register write at a falling edge; the predictor copy follows at once.
    task automatic write_reg(input logic idx, input logic [crpg_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == crpg_pkg::REG_VOLTAGE_LIMIT)
            volt_limit_cfg = val;
        else
            setpoint_cfg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Holds the sender back until every transaction has been accepted and answered.
    task automatic wait_idle();
        while (samples_accepted != samples_queued || ramp_expected.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Sender: bursts of random length with random gaps, changing at the falling edge.
    always @(negedge clk)
    begin : sample_driver
        logic        next_valid;
        logic [39:0] next_data;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else
        begin
            if (in_taken)
            begin
                in_taken   = 1'b0;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (samples_pending.size() > 0)
                begin
                    next_data  = {4'b0, samples_pending.pop_front()};
                    next_valid = 1'b1;
                    burst_left--;
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // Receiver: stall pattern drawn at random from a set of modes.
    always @(negedge clk)
    begin : result_receiver
        logic ready_next;
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 4));
        case (rx_mode)
            RX_COIN:   ready_next = 1'($urandom_range(0, 1));
            RX_THIRD:  ready_next = (rx_cycle % 3 == 0);
            RX_MOSTLY: ready_next = ($urandom_range(0, 6) != 0);
            RX_HOLD:   ready_next = 1'b0;
            default:   ready_next = 1'b1;
        endcase
        m_tready <= rst_n && ready_next;
    end

    // Monitor: predicts on each accepted sample set and checks each accepted result.
    always @(posedge clk)
    begin : stream_monitor
        sample_t      taken;
        ramp_result_t got;
        ramp_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                taken = sample_t'(s_tdata[35:0]);
                ramp_expected.push_back(governor_predict(taken));
                samples_accepted++;
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                got = ramp_result_t'(m_tdata[21:0]);
                if (ramp_expected.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = ramp_expected.pop_front();
                    if (got.power !== want.power)
                    begin
                        $error("power_level: expected %0d, got %0d", want.power, got.power);
                        mismatch_count++;
                    end
                    if (got.step !== want.step)
                    begin
                        $error("start_step: expected %0d, got %0d", want.step, got.step);
                        mismatch_count++;
                    end
                    if (got.enable !== want.enable)
                    begin
                        $error("drive_enable: expected %0d, got %0d", want.enable,
                               got.enable);
                        mismatch_count++;
                    end
                    if (got.fault !== want.fault)
                    begin
                        $error("fault_code: expected %0d, got %0d", want.fault, got.fault);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        int           n_items;
        sample_kind_t kind;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Drive off with reset registers: converter extremes and fault thresholds.
        push_sample('{12'd0, 12'd0, 12'd0});
        push_sample('{12'd4095, 12'd4095, 12'd4095});
        push_sample('{12'd0, 12'd0, 12'd1197});
        push_sample('{12'd0, 12'd0, 12'd1198});
        push_sample('{12'd3714, 12'd0, 12'd2992});
        push_sample('{12'd0, 12'd0, 12'd2993});
        push_sample('{12'd3715, 12'd0, 12'd2000});
        push_sample('{12'd0, 12'd4095, 12'd2000});
        wait_idle();

        // Drive on against the reset voltage limit: floor at zero, ramp, limits, near band.
        write_reg(crpg_pkg::REG_CURRENT_SETPOINT, 15'd20000);
        push_sample('{12'd4095, 12'd0, 12'd2000});
        push_sample('{12'd0, 12'd0, 12'd2000});
        push_sample('{12'd0, 12'd0, 12'd2000});
        push_sample('{12'd0, 12'd0, 12'd2000});
        push_sample('{12'd0, 12'd4095, 12'd2000});
        push_sample('{12'd0, 12'd3726, 12'd2000});
        push_sample('{12'd0, 12'd3725, 12'd2000});
        push_sample('{12'd2857, 12'd0, 12'd2000});
        push_sample('{12'd2858, 12'd0, 12'd2000});
        push_sample('{12'd2715, 12'd0, 12'd2000});
        push_sample('{12'd2714, 12'd0, 12'd2000});
        wait_idle();

        // Near band only counts above the minimum setpoint.
        write_reg(crpg_pkg::REG_CURRENT_SETPOINT, crpg_pkg::NEAR_MIN_SETPOINT);
        push_sample('{12'd428, 12'd0, 12'd2000});
        wait_idle();
        write_reg(crpg_pkg::REG_CURRENT_SETPOINT, crpg_pkg::NEAR_MIN_SETPOINT + 15'd1);
        push_sample('{12'd428, 12'd0, 12'd2000});
        wait_idle();
        write_reg(crpg_pkg::REG_CURRENT_SETPOINT, 15'd0);
        push_sample('{12'd428, 12'd0, 12'd2000});
        wait_idle();

        // Random phases; one long phase ramps far and works the soft start well down.
        for (int phase = 0; phase < 9; phase++)
        begin
            if (phase == 3)
            begin
                write_reg(crpg_pkg::REG_VOLTAGE_LIMIT, 15'h7FFF);
                write_reg(crpg_pkg::REG_CURRENT_SETPOINT, 15'd20000);
                for (int k = 0; k < 560; k++)
                    push_sample(draw_sample(SAMPLE_RAMP_NEAR));
                for (int k = 0; k < 20; k++)
                    push_sample(draw_sample(SAMPLE_AROUND));
                wait_idle();
                continue;
            end
            case ($urandom_range(0, 4))
                0:       write_reg(crpg_pkg::REG_VOLTAGE_LIMIT, 15'd0);
                1:       write_reg(crpg_pkg::REG_VOLTAGE_LIMIT, 15'h7FFF);
                2:       write_reg(crpg_pkg::REG_VOLTAGE_LIMIT, crpg_pkg::VOLTAGE_LIMIT_RESET);
                3:       write_reg(crpg_pkg::REG_VOLTAGE_LIMIT,
                                   crpg_pkg::CFG_W'($urandom_range(0, 30000)));
                default: write_reg(crpg_pkg::REG_VOLTAGE_LIMIT,
                                   crpg_pkg::CFG_W'($urandom_range(0, 32767)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(crpg_pkg::REG_CURRENT_SETPOINT, 15'd0);
                1:       write_reg(crpg_pkg::REG_CURRENT_SETPOINT, crpg_pkg::NEAR_MIN_SETPOINT);
                2:       write_reg(crpg_pkg::REG_CURRENT_SETPOINT,
                                   crpg_pkg::NEAR_MIN_SETPOINT + 15'd1);
                3:       write_reg(crpg_pkg::REG_CURRENT_SETPOINT, 15'd25000);
                4:       write_reg(crpg_pkg::REG_CURRENT_SETPOINT, 15'h7FFF);
                default: write_reg(crpg_pkg::REG_CURRENT_SETPOINT,
                                   crpg_pkg::CFG_W'($urandom_range(1, 25000)));
            endcase
            n_items = $urandom_range(10, 25);
            for (int k = 0; k < n_items; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: kind = SAMPLE_AROUND;
                    4, 5, 6:    kind = SAMPLE_RAMP_NEAR;
                    default:    kind = SAMPLE_NOISE;
                endcase
                push_sample(draw_sample(kind));
            end
            wait_idle();
        end

        // Let any stray result show up before the verdict.
        repeat (8) @(posedge clk);
        if (ramp_expected.size() != 0)
        begin
            $error("%0d results never arrived", ramp_expected.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS charger_power_ramp_governor_unit");
        else
            $display("FAIL charger_power_ramp_governor_unit");
        $finish;
    end

    // Watchdog for a stalled handshake.
    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL charger_power_ramp_governor_unit");
        $finish;
    end

endmodule
